// ===== sv/sha256_message_digest_core_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 digest core: assertion macros
// Shared shorthand for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_CORE_DEFINES_SVH

// same-cycle implication, muted during reset
`define SHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 core check failed");

// next-cycle implication, muted during reset
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 core check failed");

// next-cycle implication that also holds across reset
`define SHA_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sha256 core check failed");

`endif

// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest core package
// Shared types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // one 512-bit block handed from the packer to the round engine
   typedef struct packed {
      logic             last_blk;
      logic [15:0][31:0] words;
   } blk_job_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0][31:0] HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ===== sv/sha_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest core channels
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

// ===== sv/sha_fifo.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Small register FIFO of packed blocks between packer and round engine.
// ----------------------------------------------------------------------------
module sha_fifo
   import sha_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  blk_job_type push_job,
   output logic        push_space,
   input  logic        pop,
   output logic        pop_valid,
   output blk_job_type pop_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   blk_job_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_space = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_space;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte packer
// Packs message bytes big-endian into blocks, counts the bit length and
// appends the padding and length bytes at message end.
// ----------------------------------------------------------------------------
module sha_front
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sha_req_if.sink     req_chan,
   output logic        push_valid,
   output blk_job_type push_job,
   input  logic        push_space
);

   localparam logic ST_TAKE = 1'b0;
   localparam logic ST_PAD  = 1'b1;

   logic              state_ff, state_in;
   logic [5:0]        pos_ff, pos_in;
   logic [63:0]       len_ff, len_in;
   logic [15:0][31:0] words_ff, words_in;
   logic              pad_first_ff, pad_first_in;
   logic              len_ok_ff, len_ok_in;

   logic              accept;
   logic              byte_en;
   logic [7:0]        byte_val;
   logic [15:0][31:0] blk;
   logic              blk_full;

   assign req_chan.ready = (state_ff == ST_TAKE) && push_space;
   assign accept         = req_chan.valid & req_chan.ready;
   assign blk_full       = (pos_ff == 6'd63);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      words_in     = words_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      push_valid   = 1'b0;
      byte_en      = 1'b0;
      byte_val     = req_chan.data_byte;

      if (state_ff == ST_TAKE) begin
         byte_en = accept & req_chan.has_byte;
      end else begin
         byte_en = push_space;
         if (pad_first_ff) begin
            byte_val = PAD_MARK;
         end else if (len_ok_ff && (pos_ff[5:3] == 3'b111)) begin
            byte_val = len_ff[{~pos_ff[2:0], 3'b000} +: 8];
         end else begin
            byte_val = 8'h00;
         end
      end

      blk = words_ff;
      blk[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = byte_val;

      push_job.words    = blk;
      push_job.last_blk = 1'b0;

      if (byte_en) begin
         words_in = blk;
         pos_in   = pos_ff + 1'b1;
         if (blk_full) begin
            push_valid = 1'b1;
         end
      end

      if (accept) begin
         if (req_chan.has_byte) begin
            len_in = len_ff + 64'd8;
         end
         if (req_chan.end_of_message) begin
            state_in     = ST_PAD;
            pad_first_in = 1'b1;
         end
      end

      if ((state_ff == ST_PAD) && byte_en) begin
         if (pad_first_ff) begin
            pad_first_in = 1'b0;
            // set if the marker left 8 slots for the length, or filled the block so the next one is fresh
            len_ok_in    = (pos_ff <= 6'd55) || blk_full;
         end else if (blk_full) begin
            if (len_ok_ff) begin
               push_job.last_blk = 1'b1;
               state_in          = ST_TAKE;
               len_in            = '0;
            end else begin
               len_ok_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         pos_ff       <= '0;
         len_ff       <= '0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

// ===== sv/sha_back.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Runs the 64 compression rounds one per cycle with a rolling schedule,
// folds the result into the hash state and streams out the digest.
// ----------------------------------------------------------------------------
module sha_back
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  blk_job_type job,
   output logic        job_pop,
   sha_rsp_if.source   rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [5:0]        round_ff, round_in;
   logic [15:0][31:0] sched_ff, sched_in;
   logic [7:0][31:0]  vars_ff, vars_in;
   logic [7:0][31:0]  hash_ff, hash_in;
   logic              last_ff, last_in;
   logic [2:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_word_ff, out_word_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;

   logic              out_take;
   logic [31:0]       w, new_w, sg0, sg1, bs0, bs1, ch, maj, t1, t2;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.digest_word = out_word_ff;
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = out_last_ff;
   assign out_take             = out_valid_ff & rsp_chan.ready;

   // round datapath
   always_comb begin
      w     = sched_ff[0];
      sg0   = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      sg1   = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      new_w = sched_ff[0] + sg0 + sched_ff[9] + sg1;
      bs1   = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
      ch    = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      t1    = vars_ff[7] + bs1 + ch + ROUND_K[round_ff] + w;
      bs0   = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
      maj   = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]);
      t2    = bs0 + maj;
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      sched_in     = sched_ff;
      vars_in      = vars_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      job_pop      = 1'b0;

      if (out_take) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               sched_in = job.words;
               vars_in  = hash_ff;
               round_in = '0;
               last_in  = job.last_blk;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            vars_in = {vars_ff[6:4], vars_ff[3] + t1, vars_ff[2:0], t1 + t2};
            // schedule slides down one word; the new word lands 16 rounds ahead
            sched_in = {new_w, sched_ff[15:1]};
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            idx_in   = '0;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!out_valid_ff || out_take) begin
               out_valid_in = 1'b1;
               out_word_in  = hash_ff[idx_ff];
               out_idx_in   = idx_ff;
               out_last_in  = (idx_ff == 3'd7);
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  hash_in  = HASH_IV;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= HASH_IV;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff    <= round_in;
      sched_ff    <= sched_in;
      vars_ff     <= vars_in;
      last_ff     <= last_in;
      out_word_ff <= out_word_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== sv/sha256_message_digest_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Byte-stream SHA-256: packer, block queue and one-round-per-cycle engine.
// ----------------------------------------------------------------------------
// Message bytes arrive one per beat and are taken one per cycle while a
// block fills and the queue has room; a beat without has_byte only marks
// the message end. Each full 64-byte block goes into a QUEUE_DEPTH-entry
// queue; the round engine loads it, runs the 64 rounds and updates the hash
// before it takes the next block. After end_of_message the packer writes
// the 0x80 marker, zero fill and the 64-bit length one byte per cycle while
// the queue has room and takes no new beat meanwhile. The eight digest
// words then leave one per cycle while the receiver is ready, from an
// output register, word_index 0 first, last_word on the eighth, and the
// hash state returns to the initial values for the next message.
// ----------------------------------------------------------------------------
module sha256_message_digest_core
   import sha_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   logic        push_valid;
   blk_job_type push_job;
   logic        push_space;
   logic        job_valid;
   blk_job_type job;
   logic        job_pop;

   sha_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_space (push_space)
   );

   sha_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_space (push_space),
      .pop        (job_pop),
      .pop_valid  (job_valid),
      .pop_job    (job)
   );

   sha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sv/sha_chk.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest core port checker
// Watches the core's channels for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_core_defines.svh"

module sha_chk (
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   logic [2:0] exp_idx_ff;
   logic [7:0] pend_ff;
   logic       end_beat;
   logic       last_beat;

   assign end_beat  = req_chan.valid & req_chan.ready & req_chan.end_of_message;
   assign last_beat = rsp_chan.valid & rsp_chan.ready & rsp_chan.last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
         pend_ff    <= '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            exp_idx_ff <= exp_idx_ff + 1'b1;
         end
         if (end_beat && !last_beat) begin
            pend_ff <= pend_ff + 1'b1;
         end else if (last_beat && !end_beat) begin
            pend_ff <= pend_ff - 1'b1;
         end
      end
   end

   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready,
      rsp_chan.valid && $stable(rsp_chan.digest_word) && $stable(rsp_chan.word_index))
   `SHA_ASSERT_IMPL(a_word_order, clock, reset, rsp_chan.valid,
      rsp_chan.word_index == exp_idx_ff)
   `SHA_ASSERT_IMPL(a_digest_owed, clock, reset, rsp_chan.valid, pend_ff != 8'd0)
   `SHA_ASSERT_ALWAYS(a_reset_quiet, clock, reset, !rsp_chan.valid)

endmodule

bind sha256_message_digest_core sha_chk u_sha_chk (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
